// File: rtl/cte_pkg.sv
package cte_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int TabLen = 24;
    localparam int SqrtBits = 24;

    localparam logic [15:0] GainReset = 16'd1144;
    localparam logic [15:0] WeightReset = 16'd64225;

    typedef enum logic [1:0] {
        REG_BIAS_X = 2'd0,
        REG_BIAS_Y = 2'd1,
        REG_GAIN   = 2'd2,
        REG_WEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_ADD,
        ST_START_A,
        ST_WAIT_A,
        ST_START_P,
        ST_WAIT_P,
        ST_GAIN,
        ST_PRED,
        ST_BLEND_W,
        ST_BLEND_A,
        ST_BLEND_SUM,
        ST_DONE
    } state_t;

    function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
        logic signed [27:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] sat_ang(input logic signed [47:0] v);
        logic signed [17:0] r;
        if (v > 48'sd131071)
        begin
            r = 18'sd131071;
        end
        else if (v < -48'sd131072)
        begin
            r = -18'sd131072;
        end
        else
        begin
            r = 18'(v);
        end
        return r;
    endfunction

endpackage

// File: rtl/cte_if.sv
interface cte_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, output ready);
endinterface

interface cte_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] roll_fused;
    logic signed [17:0] pitch_fused;

    modport source (output valid, roll_fused, pitch_fused, input ready);
    modport sink (input valid, roll_fused, pitch_fused, output ready);
endinterface

// File: rtl/cte_isqrt.sv
module cte_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] value,
    output logic        busy,
    output logic [23:0] root
);

    localparam logic [4:0] LastCnt = 5'(cte_pkg::SqrtBits - 1);

    logic [47:0] val_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;

    logic [27:0] shifted;
    logic [27:0] trial;
    logic [27:0] diff;
    logic        ge;

    assign shifted = {rem_reg, val_reg[47:46]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge = shifted >= trial;
    assign diff = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LastCnt)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[45:0], 2'b00};
            rem_reg <= ge ? diff[25:0] : shifted[25:0];
            root_reg <= {root_reg[22:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: rtl/cte_cordic.sv
module cte_cordic #(
    parameter int STEPS = cte_pkg::CordicStepsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [25:0] y_in,
    input  logic signed [25:0] x_in,
    output logic               busy,
    output logic signed [17:0] angle
);

    localparam int Iters = (STEPS > cte_pkg::TabLen) ? cte_pkg::TabLen : STEPS;
    localparam logic [4:0] LastIdx = 5'(Iters - 1);

    logic signed [51:0] x_reg;
    logic signed [51:0] y_reg;
    logic signed [27:0] z_reg;
    logic [4:0]         idx_reg;
    logic               busy_reg;
    logic               zero_reg;

    logic signed [51:0] x_ext;
    logic signed [51:0] y_ext;
    logic signed [51:0] x_pre;
    logic signed [51:0] y_pre;
    logic signed [27:0] z_pre;
    logic signed [51:0] xs;
    logic signed [51:0] ys;
    logic signed [27:0] at;
    logic signed [28:0] z_rnd;

    assign x_ext = 52'(x_in) <<< 24;
    assign y_ext = 52'(y_in) <<< 24;

    always_comb
    begin
        x_pre = x_ext;
        y_pre = y_ext;
        z_pre = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_pre = y_ext;
                y_pre = -x_ext;
                z_pre = cte_pkg::atan_q24(5'd0) <<< 1;
            end
            else
            begin
                x_pre = -y_ext;
                y_pre = x_ext;
                z_pre = -(cte_pkg::atan_q24(5'd0) <<< 1);
            end
        end
    end

    assign xs = x_reg >>> idx_reg;
    assign ys = y_reg >>> idx_reg;
    assign at = cte_pkg::atan_q24(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == LastIdx)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_pre;
            y_reg <= y_pre;
            z_reg <= z_pre;
            zero_reg <= (x_in == 0) && (y_in == 0);
        end
        else if (busy_reg)
        begin
            if (y_reg < 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign z_rnd = (29'(z_reg) + 29'sd256) >>> 9;
    assign angle = zero_reg ? 18'sd0 : cte_pkg::sat_ang(48'(z_rnd));
    assign busy = busy_reg;

endmodule

// File: rtl/complementary_tilt_estimator.sv
// CORDIC_STEPS sets the CORDIC iterations per angle, clamped to at most 24 steps.
// The square root runs alongside the roll CORDIC, then the pitch CORDIC runs alone.
// One item is in flight at a time; a new sample is taken only after the result has been accepted.
// A shared 18 by 18 multiplier performs the squares, the rate scaling and both blends in turn.
// Reset clears both angle estimates and loads the default bias, gain and weight registers.
module complementary_tilt_estimator #(
    parameter int CORDIC_STEPS = cte_pkg::CordicStepsDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    cte_sample_if.sink   sample,
    cte_result_if.source result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cte_pkg::state_t state_reg;
    cte_pkg::state_t state_next;

    logic signed [15:0] bias_x_reg;
    logic signed [15:0] bias_y_reg;
    logic [15:0]        gain_reg;
    logic [15:0]        weight_reg;

    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    logic signed [15:0] gx_reg;
    logic signed [15:0] gy_reg;

    logic signed [17:0] roll_est_reg;
    logic signed [17:0] pitch_est_reg;
    logic signed [17:0] roll_accel_reg;
    logic signed [17:0] pitch_accel_reg;
    logic signed [17:0] pred_reg;
    logic [23:0]        mag_reg;
    logic signed [35:0] prod_reg;
    logic signed [39:0] sum_reg;
    logic               axis_reg;

    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;
    logic signed [16:0] rate_diff;
    logic [16:0]        weight_comp;
    logic signed [17:0] est_sel;
    logic signed [39:0] pred_sum;
    logic signed [39:0] blend_sum;
    logic signed [39:0] pred_shift;
    logic signed [39:0] blend_shift;
    logic signed [16:0] neg_ax;

    logic               cord_start;
    logic               cord_busy;
    logic signed [25:0] cord_y;
    logic signed [25:0] cord_x;
    logic signed [17:0] cord_angle;
    logic               sqrt_start;
    logic               sqrt_busy;
    logic [23:0]        sqrt_root;

    logic               cfg_write;
    cte_pkg::reg_idx_t  cfg_idx;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx = cte_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            cte_pkg::REG_BIAS_X: prdata = {{16{bias_x_reg[15]}}, bias_x_reg};
            cte_pkg::REG_BIAS_Y: prdata = {{16{bias_y_reg[15]}}, bias_y_reg};
            cte_pkg::REG_GAIN:   prdata = {16'd0, gain_reg};
            cte_pkg::REG_WEIGHT: prdata = {16'd0, weight_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg <= '0;
            bias_y_reg <= '0;
            gain_reg <= cte_pkg::GainReset;
            weight_reg <= cte_pkg::WeightReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                cte_pkg::REG_BIAS_X: bias_x_reg <= pwdata[15:0];
                cte_pkg::REG_BIAS_Y: bias_y_reg <= pwdata[15:0];
                cte_pkg::REG_GAIN:   gain_reg <= pwdata[15:0];
                cte_pkg::REG_WEIGHT: weight_reg <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cte_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = cte_pkg::ST_SQ_Y;
                end
            end
            cte_pkg::ST_SQ_Y:    state_next = cte_pkg::ST_SQ_Z;
            cte_pkg::ST_SQ_Z:    state_next = cte_pkg::ST_SQ_ADD;
            cte_pkg::ST_SQ_ADD:  state_next = cte_pkg::ST_START_A;
            cte_pkg::ST_START_A: state_next = cte_pkg::ST_WAIT_A;
            cte_pkg::ST_WAIT_A:
            begin
                if (!cord_busy && !sqrt_busy)
                begin
                    state_next = cte_pkg::ST_START_P;
                end
            end
            cte_pkg::ST_START_P: state_next = cte_pkg::ST_WAIT_P;
            cte_pkg::ST_WAIT_P:
            begin
                if (!cord_busy)
                begin
                    state_next = cte_pkg::ST_GAIN;
                end
            end
            cte_pkg::ST_GAIN:    state_next = cte_pkg::ST_PRED;
            cte_pkg::ST_PRED:    state_next = cte_pkg::ST_BLEND_W;
            cte_pkg::ST_BLEND_W: state_next = cte_pkg::ST_BLEND_A;
            cte_pkg::ST_BLEND_A: state_next = cte_pkg::ST_BLEND_SUM;
            cte_pkg::ST_BLEND_SUM:
            begin
                state_next = axis_reg ? cte_pkg::ST_DONE : cte_pkg::ST_GAIN;
            end
            cte_pkg::ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = cte_pkg::ST_IDLE;
                end
            end
            default:             state_next = cte_pkg::ST_IDLE;
        endcase
    end

    assign rate_diff = axis_reg ? (17'(gy_reg) - 17'(bias_y_reg))
                                : (17'(gx_reg) - 17'(bias_x_reg));
    assign weight_comp = 17'h10000 - {1'b0, weight_reg};
    assign neg_ax = -17'(ax_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        cord_start = 1'b0;
        sqrt_start = 1'b0;
        cord_y = 26'(ay_reg);
        cord_x = 26'(az_reg);
        sample.ready = 1'b0;
        result.valid = 1'b0;
        unique case (state_reg)
            cte_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
            end
            cte_pkg::ST_SQ_Y:
            begin
                mul_a = 18'(ay_reg);
                mul_b = 18'(ay_reg);
            end
            cte_pkg::ST_SQ_Z:
            begin
                mul_a = 18'(az_reg);
                mul_b = 18'(az_reg);
            end
            cte_pkg::ST_START_A:
            begin
                cord_start = 1'b1;
                sqrt_start = 1'b1;
            end
            cte_pkg::ST_START_P:
            begin
                cord_start = 1'b1;
                cord_y = 26'(neg_ax) <<< 8;
                cord_x = {2'b00, mag_reg};
            end
            cte_pkg::ST_GAIN:
            begin
                mul_a = 18'(rate_diff);
                mul_b = {2'b00, gain_reg};
            end
            cte_pkg::ST_BLEND_W:
            begin
                mul_a = {2'b00, weight_reg};
                mul_b = pred_reg;
            end
            cte_pkg::ST_BLEND_A:
            begin
                mul_a = {1'b0, weight_comp};
                mul_b = axis_reg ? pitch_accel_reg : roll_accel_reg;
            end
            cte_pkg::ST_DONE:
            begin
                result.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign result.roll_fused = roll_est_reg;
    assign result.pitch_fused = pitch_est_reg;

    assign mul_p = mul_a * mul_b;
    assign est_sel = axis_reg ? pitch_est_reg : roll_est_reg;
    assign pred_sum = (40'(est_sel) <<< 16) + 40'(prod_reg) + 40'sd32768;
    assign pred_shift = pred_sum >>> 16;
    assign blend_sum = sum_reg + 40'(prod_reg) + 40'sd32768;
    assign blend_shift = blend_sum >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cte_pkg::ST_IDLE;
            roll_est_reg <= '0;
            pitch_est_reg <= '0;
            axis_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cte_pkg::ST_WAIT_P)
            begin
                axis_reg <= 1'b0;
            end
            else if (state_reg == cte_pkg::ST_BLEND_SUM)
            begin
                axis_reg <= 1'b1;
                if (axis_reg)
                begin
                    pitch_est_reg <= cte_pkg::sat_ang(48'(blend_shift));
                end
                else
                begin
                    roll_est_reg <= cte_pkg::sat_ang(48'(blend_shift));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (sample.valid && sample.ready)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            az_reg <= sample.accel_z;
            gx_reg <= sample.rate_x;
            gy_reg <= sample.rate_y;
        end
        case (state_reg)
            cte_pkg::ST_SQ_Z:    sum_reg <= 40'(prod_reg);
            cte_pkg::ST_SQ_ADD:  sum_reg <= sum_reg + 40'(prod_reg);
            cte_pkg::ST_BLEND_A: sum_reg <= 40'(prod_reg);
            cte_pkg::ST_PRED:    pred_reg <= cte_pkg::sat_ang(48'(pred_shift));
            cte_pkg::ST_WAIT_A:
            begin
                roll_accel_reg <= cord_angle;
                mag_reg <= sqrt_root;
            end
            cte_pkg::ST_WAIT_P:  pitch_accel_reg <= cord_angle;
            default:
            begin
            end
        endcase
    end

    cte_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .y_in  (cord_y),
        .x_in  (cord_x),
        .busy  (cord_busy),
        .angle (cord_angle)
    );

    cte_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value ({sum_reg[31:0], 16'd0}),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !sample.ready)
        else $error("Result offered while a new sample could be taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("Second sample taken straight after a transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cord_start |-> !cord_busy)
        else $error("CORDIC started while still iterating.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready) |=> sample.ready)
        else $error("Block did not return to idle after the result transfer.");

endmodule

// File: tb/complementary_tilt_estimator_tb.sv
`timescale 1ns / 100ps

module complementary_tilt_estimator_tb;

    localparam int CordicSteps = 16;
    localparam int CycleLimit = 1500000;
    localparam int DrainCycles = 120;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } imu_sample_t;

    typedef struct packed {
        logic signed [17:0] roll;
        logic signed [17:0] pitch;
    } tilt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cte_sample_if sample ();
    cte_result_if result ();

    complementary_tilt_estimator #(.CORDIC_STEPS(CordicSteps)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample.sink),
        .result(result.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    longint bias_x_q;
    longint bias_y_q;
    longint gain_q;
    longint weight_q;
    longint roll_est_q;
    longint pitch_est_q;
    tilt_t expected_tilt[$];
    int fail_count = 0;
    int stall_min = 0;
    int stall_max = 3;
    int hold_off = 0;
    longint cycle_count = 0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > 131071)
        begin
            return 131071;
        end
        if (v < -131072)
        begin
            return -131072;
        end
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                            131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic longint vector_angle(longint y_in, longint x_in);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x_in == 0 && y_in == 0)
        begin
            return 0;
        end
        x = x_in * 16777216;
        y = y_in * 16777216;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = arctan_step(0) * 2;
            end
            else
            begin
                x = -y;
                y = t;
                z = -arctan_step(0) * 2;
            end
        end
        for (int i = 0; i < CordicSteps && i < 24; i++)
        begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y < 0)
            begin
                x -= ys;
                y += xs;
                z -= arctan_step(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += arctan_step(i);
            end
        end
        return clamp_angle(floor_shr(z + 256, 9));
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint blend_angle(longint est, longint rate, longint bias,
                                           longint acc);
        longint p;
        p = est * 65536 + (rate - bias) * gain_q;
        p = clamp_angle(floor_shr(p + 32768, 16));
        return clamp_angle(floor_shr(weight_q * p + (65536 - weight_q) * acc + 32768, 16));
    endfunction

    function automatic tilt_t fuse_sample(imu_sample_t s);
        longint roll_ref;
        longint pitch_ref;
        longint mag;
        tilt_t r;
        roll_ref = vector_angle(s.ay, s.az);
        mag = int_sqrt((longint'(s.ay) * s.ay + longint'(s.az) * s.az) << 16);
        pitch_ref = vector_angle(-longint'(s.ax) * 256, mag);
        roll_est_q = blend_angle(roll_est_q, s.gx, bias_x_q, roll_ref);
        pitch_est_q = blend_angle(pitch_est_q, s.gy, bias_y_q, pitch_ref);
        r.roll = 18'(roll_est_q);
        r.pitch = 18'(pitch_est_q);
        return r;
    endfunction

    function automatic int random_gap(int lo, int hi);
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(hi, hi * 10);
        end
        return $urandom_range(lo, hi);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            result.ready <= ($urandom_range(0, 3) != 0) ? 1'b1
                            : (random_gap(stall_min, stall_max) == 0);
        end
    end

    always @(posedge clk)
    begin
        tilt_t exp_t;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_tilt.size() == 0)
            begin
                $error("unexpected transfer roll %0d pitch %0d", result.roll_fused,
                       result.pitch_fused);
                fail_count++;
            end
            else
            begin
                exp_t = expected_tilt.pop_front();
                if (result.roll_fused !== exp_t.roll)
                begin
                    $error("roll_fused expected %0d actual %0d", exp_t.roll,
                           result.roll_fused);
                    fail_count++;
                end
                if (result.pitch_fused !== exp_t.pitch)
                begin
                    $error("pitch_fused expected %0d actual %0d", exp_t.pitch,
                           result.pitch_fused);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(imu_sample_t s, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? random_gap(1, 3) : 0);
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid <= 1'b1;
        sample.accel_x <= s.ax;
        sample.accel_y <= s.ay;
        sample.accel_z <= s.az;
        sample.rate_x <= s.gx;
        sample.rate_y <= s.gy;
        expected_tilt.push_back(fuse_sample(s));
        @(posedge clk);
        while (!sample.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample.valid <= 1'b0;
        while (expected_tilt.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_register(cte_pkg::reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cte_pkg::REG_BIAS_X: bias_x_q = longint'(signed'(value[15:0]));
            cte_pkg::REG_BIAS_Y: bias_y_q = longint'(signed'(value[15:0]));
            cte_pkg::REG_GAIN: gain_q = value[15:0];
            default: weight_q = value[15:0];
        endcase
    endtask

    task automatic configure(int bx, int by, int gain, int weight);
        wait_idle();
        write_register(cte_pkg::REG_BIAS_X, 32'(bx));
        write_register(cte_pkg::REG_BIAS_Y, 32'(by));
        write_register(cte_pkg::REG_GAIN, 32'(gain));
        write_register(cte_pkg::REG_WEIGHT, 32'(weight));
    endtask

    function automatic imu_sample_t make_sample(int ax, int ay, int az, int gx, int gy);
        imu_sample_t s;
        s.ax = 16'(ax);
        s.ay = 16'(ay);
        s.az = 16'(az);
        s.gx = 16'(gx);
        s.gy = 16'(gy);
        return s;
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        s = imu_sample_t'(80'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 3) == 0)
        begin
            s.ay = 16'($urandom_range(0, 8)) - 16'sd4;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            s.az = 16'($urandom_range(0, 8)) - 16'sd4;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            s.ax = 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
        end
        return s;
    endfunction

    task automatic test_directed();
        send_sample(make_sample(0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 16384, 0, 0));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
        send_sample(make_sample(0, 100, -200, 5, -5));
        send_sample(make_sample(0, -100, -200, 0, 0));
        send_sample(make_sample(0, 0, -1, 0, 0));
        send_sample(make_sample(500, 0, 0, 0, 0));
        send_sample(make_sample(-500, -32768, 0, 0, 0));
        send_sample(make_sample(1, 32767, -32768, 1, -1));
    endtask

    task automatic test_saturation();
        configure(-32768, 32767, 65535, 65535);
        for (int i = 0; i < 8; i++)
        begin
            send_sample(make_sample(0, 0, 0, 32767, -32768));
        end
        configure(32767, -32768, 65535, 65535);
        for (int i = 0; i < 6; i++)
        begin
            send_sample(make_sample(0, 0, 0, -32768, 32767));
        end
        configure(0, 0, 0, 0);
        send_sample(make_sample(100, 0, 300, 0, 0));
        send_sample(make_sample(-300, 300, 0, 0, 0));
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        for (int i = 0; i < 6; i++)
        begin
            send_sample(random_sample(), 1);
        end
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            send_sample(random_sample());
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 350 == 0)
            begin
                configure(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768,
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 4000),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(60000, 65535));
                stall_max = $urandom_range(0, 4);
            end
            send_sample(random_sample());
        end
    endtask

    initial
    begin
        sample.valid = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        sample.rate_x = '0;
        sample.rate_y = '0;
        bias_x_q = 0;
        bias_y_q = 0;
        gain_q = cte_pkg::GainReset;
        weight_q = cte_pkg::WeightReset;
        roll_est_q = 0;
        pitch_est_q = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_saturation();
        configure(0, 0, cte_pkg::GainReset, cte_pkg::WeightReset);
        test_backpressure();
        test_random(1720);
        wait_idle();
        if (fail_count == 0 && expected_tilt.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/cte_pkg.sv
rtl/cte_if.sv
rtl/cte_isqrt.sv
rtl/cte_cordic.sv
rtl/complementary_tilt_estimator.sv
tb/complementary_tilt_estimator_tb.sv
